>>> src/sib_pkg.sv
// Shared types and constants for the spectral irregularity block.
// No dependencies; imported by every module of the block.
package sib_pkg;

    // Field widths
    localparam int AMP_W  = 16;
    localparam int RMS_W  = 16;
    localparam int SUM_W  = 18;            // three-bin sum and deviation
    localparam int PROD_W = 2 * SUM_W;     // sum times deviation
    localparam int WDS_W  = 48;            // weighted deviation accumulator
    localparam int LMS_W  = 30;            // local mean accumulator
    localparam int RL_W   = RMS_W + LMS_W; // rms times local mean sum
    localparam int DEN_W  = 48;            // 3 * rms * local mean sum
    localparam int FRAC_W = 16;            // fraction bits of Q16.16
    localparam int QUO_W  = 32;            // result width
    localparam int CNT_W  = $clog2(QUO_W);

    // One finished frame handed from front to back
    typedef struct packed {
        logic [WDS_W-1:0] wds;
        logic [LMS_W-1:0] lms;
        logic [RMS_W-1:0] rms;
    } t_job;

    // Back-end divider sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } t_back_state;

endpackage

>>> src/sib_front.sv
// Front end: takes bins, keeps the three-bin window and the frame accumulators.
// Depends on sib_pkg; pushes one t_job per frame into sib_queue.
module sib_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [15:0]           i_amplitude,
    input  logic                  i_frame_end,
    input  logic [15:0]           i_frame_rms,
    output logic                  o_push,
    output sib_pkg::t_job         o_job,
    input  logic                  i_full
);
    import sib_pkg::*;

    logic [AMP_W-1:0]  r_older;
    logic [AMP_W-1:0]  r_newer;
    logic [1:0]        r_fill;

    logic              r_p1_valid;
    logic              r_p1_last;
    logic              r_p1_contrib;
    logic [SUM_W-1:0]  r_p1_sum;
    logic [SUM_W-1:0]  r_p1_dev;
    logic [RMS_W-1:0]  r_p1_rms;

    logic              r_p2_valid;
    logic              r_p2_last;
    logic              r_p2_contrib;
    logic [PROD_W-1:0] r_p2_prod;
    logic [SUM_W-1:0]  r_p2_sum;
    logic [RMS_W-1:0]  r_p2_rms;

    logic [WDS_W-1:0]  r_wds;
    logic [LMS_W-1:0]  r_lms;

    logic              w_adv;
    logic              w_take;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_three_a;
    logic [SUM_W-1:0]  w_dev;
    logic [PROD_W-1:0] w_prod;
    logic [WDS_W-1:0]  w_wds_next;
    logic [LMS_W-1:0]  w_lms_next;

    // Stall the whole pipe only when a frame end cannot enter the queue
    assign w_adv   = !(r_p2_valid && r_p2_last && i_full);
    assign o_ready = w_adv;
    assign w_take  = i_valid && w_adv;

    // Three-bin sum and absolute deviation of the middle bin
    assign w_sum     = SUM_W'(r_older) + SUM_W'(r_newer) + SUM_W'(i_amplitude);
    assign w_three_a = SUM_W'({r_newer, 1'b0}) + SUM_W'(r_newer);
    assign w_dev     = (w_three_a >= w_sum) ? (w_three_a - w_sum) : (w_sum - w_three_a);

    assign w_prod = r_p1_sum * r_p1_dev;

    // Accumulate the bin leaving the pipe
    assign w_wds_next = r_wds + (r_p2_contrib ? WDS_W'(r_p2_prod) : '0);
    assign w_lms_next = r_lms + (r_p2_contrib ? LMS_W'(r_p2_sum) : '0);

    assign o_push    = r_p2_valid && r_p2_last && w_adv;
    assign o_job.wds = w_wds_next;
    assign o_job.lms = w_lms_next;
    assign o_job.rms = r_p2_rms;

    // Advance window: shift in each bin, clear at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older <= '0;
            r_newer <= '0;
            r_fill  <= '0;
        end else if (w_take) begin
            if (i_frame_end) begin
                r_older <= '0;
                r_newer <= '0;
                r_fill  <= '0;
            end else begin
                r_older <= r_newer;
                r_newer <= i_amplitude;
                if (r_fill != 2'd2) begin
                    r_fill <= r_fill + 2'd1;
                end
            end
        end
    end

    // Pipeline valid and control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else if (w_adv) begin
            r_p1_valid <= i_valid;
            r_p2_valid <= r_p1_valid;
        end
    end

    // Pipeline payload: stage one forms sum and deviation, stage two multiplies
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_last    <= i_frame_end;
            r_p1_contrib <= (r_fill == 2'd2);
            r_p1_sum     <= w_sum;
            r_p1_dev     <= w_dev;
            r_p1_rms     <= i_frame_rms;
            r_p2_last    <= r_p1_last;
            r_p2_contrib <= r_p1_contrib;
            r_p2_prod    <= w_prod;
            r_p2_sum     <= r_p1_sum;
            r_p2_rms     <= r_p1_rms;
        end
    end

    // Frame accumulators, cleared once the frame is handed off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wds <= '0;
            r_lms <= '0;
        end else if (w_adv && r_p2_valid) begin
            if (r_p2_last) begin
                r_wds <= '0;
                r_lms <= '0;
            end else begin
                r_wds <= w_wds_next;
                r_lms <= w_lms_next;
            end
        end
    end

endmodule

>>> src/sib_queue.sv
// Small FIFO of finished-frame jobs between front end and divider.
// Depends on sib_pkg for the t_job payload.
module sib_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sib_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output sib_pkg::t_job o_job,
    output logic          o_empty
);
    import sib_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_do_push;
    logic            w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_job     = r_mem[r_rd_ptr];

    // Write entry
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> src/sib_back.sv
// Back end: forms 3*rms*sum(s) and divides the weighted deviation by it,
// one quotient bit per cycle. Depends on sib_pkg.
module sib_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  sib_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_irregularity,
    output logic          o_status
);
    import sib_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;

    t_job               r_job;
    logic [RL_W-1:0]    r_prod;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_lo;
    logic [QUO_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic [QUO_W-1:0]   r_result;
    logic               r_status;

    logic [RL_W-1:0]    w_rl;
    logic               w_den_zero;
    logic               w_sat;
    logic [DEN_W:0]     w_trial;
    logic               w_ge;
    logic [DEN_W:0]     w_diff;

    assign w_rl       = r_job.rms * r_job.lms;
    assign w_den_zero = (r_den == '0);
    assign w_sat      = {{FRAC_W{1'b0}}, r_job.wds} >= {r_den, {FRAC_W{1'b0}}};
    assign w_trial    = {r_rem, r_lo[QUO_W-1]};
    assign w_ge       = (w_trial >= {1'b0, r_den});
    assign w_diff     = w_trial - {1'b0, r_den};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_SCALE;
            ST_SCALE: n_state = ST_CHECK;
            ST_CHECK: begin
                if (w_den_zero || w_sat) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs decoded from state
    always_comb begin
        o_pop   = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: o_pop   = !i_empty;
            ST_OUT:  o_valid = 1'b1;
            default: begin
                o_pop   = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    assign o_irregularity = r_result;
    assign o_status       = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: load job, form denominator, run restoring division
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    r_job <= i_job;
                end
            end
            ST_MUL: begin
                r_prod <= w_rl;
            end
            ST_SCALE: begin
                r_den <= DEN_W'({r_prod, 1'b0}) + DEN_W'(r_prod);
            end
            ST_CHECK: begin
                r_rem <= DEN_W'(r_job.wds[WDS_W-1:FRAC_W]);
                r_lo  <= {r_job.wds[FRAC_W-1:0], {FRAC_W{1'b0}}};
                r_quo <= '0;
                r_cnt <= CNT_W'(QUO_W - 1);
                if (w_den_zero) begin
                    r_result <= '0;
                    r_status <= 1'b1;
                end else if (w_sat) begin
                    r_result <= '1;
                    r_status <= 1'b0;
                end
            end
            ST_DIV: begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_lo  <= {r_lo[QUO_W-2:0], 1'b0};
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_result <= {r_quo[QUO_W-2:0], w_ge};
                    r_status <= 1'b0;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

>>> src/spectral_irregularity_beauchamp_top.sv
// Spectral irregularity (Beauchamp) over a streamed frame of bin magnitudes.
//
// Input stream: one bin per transaction. i_s_tdata carries amplitude and the
// frame RMS; i_s_tlast marks the last bin, and the RMS is sampled only there.
// Output stream: one transaction per frame. o_m_tdata is the irregularity
// in unsigned Q16.16, saturated at all ones; o_m_tuser is the status
// (1 = zero denominator, result forced to 0).
// Throughput: one bin per cycle while the queue has room. A front pipeline
// accumulates the frame; finished frames wait in a QUEUE_DEPTH-entry queue
// for the divider, which pops a job, forms the denominator, checks it and
// runs the one-bit-per-cycle restoring divide before the output handshake;
// the divide is skipped when the denominator is zero or the ratio saturates.
// The divider takes no new frame until its result is accepted. When frames
// are shorter than the divider time the queue fills and the input is
// back-pressured. When the receiver stalls, the result is held and the
// front keeps accepting bins until the queue is full.
// Reset (synchronous, active low) clears the window, the accumulators,
// the queue and the divider; no result is pending afterward.
module spectral_irregularity_beauchamp_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] amplitude, [31:16] frame_rms
    input  logic        i_s_tlast,   // frame_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] irregularity
    output logic        o_m_tuser    // [0] status
);
    import sib_pkg::*;

    t_job w_push_job;
    t_job w_pop_job;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;

    sib_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_amplitude (i_s_tdata[15:0]),
        .i_frame_end (i_s_tlast),
        .i_frame_rms (i_s_tdata[31:16]),
        .o_push      (w_push),
        .o_job       (w_push_job),
        .i_full      (w_full)
    );

    sib_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    sib_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_job          (w_pop_job),
        .o_pop          (w_pop),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_irregularity (o_m_tdata),
        .o_status       (o_m_tuser)
    );

endmodule

>>> bench/tb_spectral_irregularity_beauchamp_top.sv
// Self-checking bench for the Beauchamp spectral irregularity block.
// Streams frames of bin magnitudes and checks each frame result against a local predictor.
// Depends on sib_pkg and spectral_irregularity_beauchamp_top.
`timescale 1ns / 100ps

module tb_spectral_irregularity_beauchamp_top;
    import sib_pkg::*;

    localparam int RUN_LIMIT   = 400000;
    localparam int PHASE_BINS  = 250;
    localparam int SHOW_ERRORS = 10;

    // One input bin as the driver sees it
    typedef struct packed {
        logic [RMS_W-1:0] rms;
        logic             frame_end;
        logic [AMP_W-1:0] amplitude;
    } t_bin_item;

    // One frame result
    typedef struct packed {
        logic [QUO_W-1:0] irregularity;
        logic             status;
    } t_irr_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // [15:0] amplitude, [31:16] frame_rms
    logic        i_s_tlast  = 1'b0; // frame_end
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // [31:0] irregularity
    logic        o_m_tuser;         // [0] status

    // Predictor state: sliding window and frame accumulators
    logic [AMP_W-1:0] win_older = '0;
    logic [AMP_W-1:0] win_newer = '0;
    logic [1:0]       win_fill  = '0;
    logic [WDS_W-1:0] dev_acc   = '0;
    logic [LMS_W-1:0] mean_acc  = '0;

    t_bin_item   feed_q[$];
    t_irr_result irr_expect_q[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  bins_queued    = 0;
    int  frames_queued  = 0;
    int  bins_accepted  = 0;
    int  results_seen   = 0;
    int  n_fail         = 0;
    int  cycle_count    = 0;
    bit  bin_taken      = 1'b0;

    spectral_irregularity_beauchamp_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Fold one accepted bin into the window; on frame end compute the ratio
    task automatic absorb_bin(input logic [AMP_W-1:0] amp, input logic frame_end,
                              input logic [RMS_W-1:0] rms);
        logic [SUM_W-1:0]        tri_sum;
        logic [SUM_W-1:0]        mid_x3;
        logic [SUM_W-1:0]        dev;
        logic [DEN_W-1:0]        den;
        logic [DEN_W-1:0]        quo;
        logic [DEN_W-1:0]        rem;
        logic [DEN_W+FRAC_W-1:0] frac_num;
        t_irr_result             res;
        if (win_fill >= 2) begin
            tri_sum  = SUM_W'(win_older) + SUM_W'(win_newer) + SUM_W'(amp);
            mid_x3   = SUM_W'(win_newer) * SUM_W'(3);
            dev      = (mid_x3 >= tri_sum) ? mid_x3 - tri_sum : tri_sum - mid_x3;
            dev_acc  = dev_acc + WDS_W'(tri_sum) * WDS_W'(dev);
            mean_acc = mean_acc + LMS_W'(tri_sum);
        end else begin
            win_fill = win_fill + 2'd1;
        end
        win_older = win_newer;
        win_newer = amp;
        if (frame_end) begin
            den = DEN_W'(3) * DEN_W'(rms) * DEN_W'(mean_acc);
            res = '0;
            if (den == '0) begin
                res.status = 1'b1;
            end else begin
                quo = dev_acc / den;
                rem = dev_acc % den;
                if (quo >= DEN_W'(65536)) begin
                    res.irregularity = '1;
                end else begin
                    frac_num = {rem, {FRAC_W{1'b0}}};
                    res.irregularity = {quo[15:0], {FRAC_W{1'b0}}}
                                     + QUO_W'(frac_num / (DEN_W+FRAC_W)'(den));
                end
            end
            irr_expect_q.push_back(res);
            win_older = '0;
            win_newer = '0;
            win_fill  = '0;
            dev_acc   = '0;
            mean_acc  = '0;
        end
    endtask

    task automatic queue_bin(input logic [AMP_W-1:0] amp, input logic frame_end,
                             input logic [RMS_W-1:0] rms);
        feed_q.push_back('{rms: rms, frame_end: frame_end, amplitude: amp});
        bins_queued++;
        if (frame_end)
            frames_queued++;
    endtask

    function automatic logic [AMP_W-1:0] pick_amp(input int mode);
        case (mode)
            1:       pick_amp = AMP_W'($urandom_range(0, 15));
            2:       pick_amp = AMP_W'($urandom_range(65280, 65535));
            3:       pick_amp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            4:       pick_amp = ($urandom_range(0, 3) == 0) ? AMP_W'($urandom) : 16'h0000;
            default: pick_amp = AMP_W'($urandom);
        endcase
    endfunction

    // Mostly short frames so results come often; now and then a long one
    task automatic queue_random_frame();
        int               len;
        int               mode;
        int               pick;
        logic [RMS_W-1:0] rms;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            len = $urandom_range(1, 2);
        else if (pick < 80)
            len = $urandom_range(3, 16);
        else if (pick < 95)
            len = $urandom_range(17, 80);
        else
            len = $urandom_range(81, 400);
        mode = $urandom_range(0, 4);
        case ($urandom_range(0, 9))
            0:       rms = 16'h0000;
            1:       rms = 16'h0001;
            2:       rms = 16'hFFFF;
            default: rms = RMS_W'($urandom);
        endcase
        for (int i = 0; i < len; i++)
            queue_bin(pick_amp(mode), i == len - 1,
                      (i == len - 1) ? rms : RMS_W'($urandom));
    endtask

    task automatic report_mismatch(input string what, input t_irr_result want,
                                   input t_irr_result got);
        n_fail++;
        if (n_fail <= SHOW_ERRORS)
            $display("[%0t] %s: expected irregularity=%08h status=%0d, got %08h status=%0d",
                     $realtime, what, want.irregularity, want.status,
                     got.irregularity, got.status);
    endtask

    // Drive bins at the falling edge; advance only after a transaction
    always @(negedge i_clk) begin : drive_bins
        t_bin_item item;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || bin_taken) begin
            if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                item = feed_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {item.rms, item.amplitude};
                i_s_tlast  <= item.frame_end;
            end else begin
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= $urandom;
                i_s_tlast  <= $urandom_range(0, 1);
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Predict on accepted bins, check accepted results in order
    always @(posedge i_clk) begin : watch_ports
        t_irr_result got;
        t_irr_result want;
        bin_taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (bin_taken) begin
            bins_accepted++;
            absorb_bin(i_s_tdata[15:0], i_s_tlast, i_s_tdata[31:16]);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{irregularity: o_m_tdata, status: o_m_tuser};
            results_seen++;
            if (irr_expect_q.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = irr_expect_q.pop_front();
                if (got.irregularity !== want.irregularity || got.status !== want.status)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, irr_expect_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int phase_bins;
        int phase_frames;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase

            if (ph == 0) begin
                // Single-bin frame: no interior bin, zero denominator
                queue_bin(16'hFFFF, 1'b1, 16'hFFFF);
                // Two bins: still no interior bin
                queue_bin(16'h0000, 1'b0, 16'hFFFF);
                queue_bin(16'hFFFF, 1'b1, 16'h0001);
                // Zero rms forces status
                queue_bin(16'h0000, 1'b0, RMS_W'($urandom));
                queue_bin(16'hFFFF, 1'b0, RMS_W'($urandom));
                queue_bin(16'h0000, 1'b1, 16'h0000);
                // All-zero bins: local mean sum stays zero
                queue_bin(16'h0000, 1'b0, 16'hFFFF);
                queue_bin(16'h0000, 1'b0, 16'hFFFF);
                queue_bin(16'h0000, 1'b1, 16'h0005);
                // Flat frame at full scale: zero deviation
                queue_bin(16'hFFFF, 1'b0, 16'h0000);
                queue_bin(16'hFFFF, 1'b0, 16'h0000);
                queue_bin(16'hFFFF, 1'b1, 16'hFFFF);
                // Alternating extremes with rms one: largest unwrapped ratio
                queue_bin(16'h0000, 1'b0, 16'hFFFF);
                queue_bin(16'hFFFF, 1'b0, 16'hFFFF);
                queue_bin(16'h0000, 1'b0, 16'hFFFF);
                queue_bin(16'hFFFF, 1'b1, 16'h0001);
                // Ramp into a spike; rms on inner bins must be ignored
                queue_bin(16'h0001, 1'b0, 16'hFFFF);
                queue_bin(16'h0002, 1'b0, 16'h1234);
                queue_bin(16'h0003, 1'b0, 16'hFFFF);
                queue_bin(16'hFFFF, 1'b0, 16'h0000);
                queue_bin(16'h0000, 1'b1, 16'h8000);
            end

            phase_bins   = bins_queued;
            phase_frames = frames_queued;
            while (bins_queued - phase_bins < PHASE_BINS || frames_queued - phase_frames < 10)
                queue_random_frame();

            // Hold until every bin is taken and every result has come back
            while (bins_accepted != bins_queued || irr_expect_q.size() != 0)
                @(posedge i_clk);
        end

        // Quiet tail: catch any stray result
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (64) @(posedge i_clk);

        $display("Streamed %0d bins in %0d frames over four pacing phases;", bins_accepted,
                 frames_queued);
        $display("checked %0d frame results, %0d failures.", results_seen, n_fail);
        if (n_fail == 0 && irr_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
src/sib_pkg.sv
src/sib_front.sv
src/sib_queue.sv
src/sib_back.sv
src/spectral_irregularity_beauchamp_top.sv
bench/tb_spectral_irregularity_beauchamp_top.sv
